>>> design/ihq_pkg.sv
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared types and constants for the indexed max-heap queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DEFAULT_KEY_BITS = 32;
    localparam int ID_BITS          = 6;
    localparam int ID_COUNT         = 64;
    localparam int IN_KEY_BITS      = 32;
    localparam int STATUS_BITS      = 3;
    localparam int COUNT_BITS       = 7;

    // operation codes
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_RAISE = 2'd2;
    localparam logic [1:0] FUNC_LOWER = 2'd3;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_DUP     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_RD,
        S_LAST_RD,
        S_UP_REQ,
        S_UP_CMP,
        S_DN_REQ,
        S_DN_L,
        S_DN_R,
        S_FIN,
        S_RESP
    } t_state;

endpackage

>>> design/indexed_max_heap_queue_top.sv
// Push climbs the heap level by level (read parent, compare), raise-key after a slot lookup;
// pop and lower-key descend level by level, reading the left and then the right child.
// Throughput: one word at a time; the sift loop over the heap RAM read port sets it.
// Reset clears the count, the id valid bits and the handshake state at once;
// the heap and slot-map RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// indexed_max_heap_queue_top
// Binary max-heap of (id, key) entries with an id-to-slot map, both in RAM.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue_top #(
    parameter int CAPACITY = ihq_pkg::DEFAULT_CAPACITY,
    parameter int KEY_BITS = ihq_pkg::DEFAULT_KEY_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_func,
    input  logic [ihq_pkg::ID_BITS-1:0]           i_beacon_id,
    input  logic signed [ihq_pkg::IN_KEY_BITS-1:0] i_new_key,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ihq_pkg::STATUS_BITS-1:0]       o_status,
    output logic                                  o_top_valid,
    output logic [ihq_pkg::ID_BITS-1:0]           o_top_id,
    output logic signed [ihq_pkg::IN_KEY_BITS-1:0] o_top_key,
    output logic [ihq_pkg::COUNT_BITS-1:0]        o_entry_count
);

    import ihq_pkg::*;

    localparam int DEPTH = (CAPACITY < ID_COUNT) ? CAPACITY : ID_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = ID_BITS + KEY_BITS;

    // control registers
    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [ID_COUNT-1:0]     r_id_valid, n_id_valid;
    logic                    r_ov, n_ov;

    // payload registers
    logic [1:0]              r_func, n_func;
    logic [ID_BITS-1:0]      r_cur_id, n_cur_id;
    logic signed [KEY_BITS-1:0] r_cur_key, n_cur_key;
    logic [AW-1:0]           r_cur_slot, n_cur_slot;
    logic [ID_BITS-1:0]      r_left_id, n_left_id;
    logic signed [KEY_BITS-1:0] r_left_key, n_left_key;
    logic                    r_has_r, n_has_r;
    logic [STATUS_BITS-1:0]  r_status, n_status;
    logic [ID_BITS-1:0]      r_top_id, n_top_id;
    logic signed [KEY_BITS-1:0] r_top_key, n_top_key;
    logic [STATUS_BITS-1:0]  r_o_status, n_o_status;
    logic                    r_o_top_valid, n_o_top_valid;
    logic [ID_BITS-1:0]      r_o_top_id, n_o_top_id;
    logic signed [IN_KEY_BITS-1:0] r_o_top_key, n_o_top_key;
    logic [COUNT_BITS-1:0]   r_o_count, n_o_count;

    // memory ports
    logic                    heap_we, heap_re;
    logic [AW-1:0]           heap_waddr, heap_raddr;
    logic [EW-1:0]           heap_wdata, heap_rdata;
    logic                    map_we, map_re;
    logic [ID_BITS-1:0]      map_waddr;
    logic [AW-1:0]           map_wdata, map_rdata;

    // helpers
    logic [AW:0]             left_idx, right_idx, count_x, map_slot_x;
    logic [ID_BITS-1:0]      rd_id;
    logic signed [KEY_BITS-1:0] rd_key, in_key;
    logic [AW-1:0]           parent_idx;
    logic                    take_l, take_r;

    ihq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_heap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (heap_we),
        .i_wr_addr (heap_waddr),
        .i_wr_data (heap_wdata),
        .i_rd_en   (heap_re),
        .i_rd_addr (heap_raddr),
        .o_rd_data (heap_rdata)
    );

    ihq_ram #(.WIDTH(AW), .DEPTH(ID_COUNT)) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (map_we),
        .i_wr_addr (map_waddr),
        .i_wr_data (map_wdata),
        .i_rd_en   (map_re),
        .i_rd_addr (i_beacon_id),
        .o_rd_data (map_rdata)
    );

    // index arithmetic and read word split
    assign left_idx   = {r_cur_slot, 1'b1};
    assign right_idx  = left_idx + (AW+1)'(1);
    assign parent_idx = AW'((r_cur_slot - AW'(1)) >> 1);
    assign count_x    = (AW+1)'(r_count);
    assign map_slot_x = {1'b0, map_rdata};
    assign rd_id      = heap_rdata[EW-1 -: ID_BITS];
    assign rd_key     = heap_rdata[KEY_BITS-1:0];
    assign in_key     = KEY_BITS'(i_new_key);

    // sift-down child choice, left first, right only if strictly greater
    assign take_l = r_left_key > r_cur_key;
    assign take_r = r_has_r && (take_l ? (rd_key > r_left_key) : (rd_key > r_cur_key));

    // next state and datapath
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_id_valid    = r_id_valid;
        n_ov          = r_ov;
        n_func        = r_func;
        n_cur_id      = r_cur_id;
        n_cur_key     = r_cur_key;
        n_cur_slot    = r_cur_slot;
        n_left_id     = r_left_id;
        n_left_key    = r_left_key;
        n_has_r       = r_has_r;
        n_status      = r_status;
        n_top_id      = r_top_id;
        n_top_key     = r_top_key;
        n_o_status    = r_o_status;
        n_o_top_valid = r_o_top_valid;
        n_o_top_id    = r_o_top_id;
        n_o_top_key   = r_o_top_key;
        n_o_count     = r_o_count;
        heap_we       = 1'b0;
        heap_waddr    = r_cur_slot;
        heap_wdata    = {r_cur_id, r_cur_key};
        heap_re       = 1'b0;
        heap_raddr    = parent_idx;
        map_we        = 1'b0;
        map_waddr     = r_cur_id;
        map_wdata     = r_cur_slot;
        map_re        = 1'b0;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func   = i_func;
                    n_cur_id = i_beacon_id;
                    n_cur_key = in_key;
                    n_status = ST_OK;
                    unique case (i_func)
                        FUNC_PUSH: begin
                            if (r_id_valid[i_beacon_id]) begin
                                n_status = ST_DUP;
                                n_state  = S_RESP;
                            end else if (count_x >= (AW+1)'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_id_valid[i_beacon_id] = 1'b1;
                                n_cur_slot = AW'(r_count);
                                n_count    = r_count + CW'(1);
                                n_state    = S_UP_REQ;
                            end
                        end
                        FUNC_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_id_valid[r_top_id] = 1'b0;
                                n_count = r_count - CW'(1);
                                if (r_count == CW'(1)) begin
                                    n_state = S_RESP;
                                end else begin
                                    heap_re    = 1'b1;
                                    heap_raddr = AW'(r_count - CW'(1));
                                    n_state    = S_LAST_RD;
                                end
                            end
                        end
                        default: begin
                            map_re  = 1'b1;
                            n_state = S_MAP_RD;
                        end
                    endcase
                end
            end

            // slot lookup for a key change
            S_MAP_RD: begin
                if (!r_id_valid[r_cur_id] || map_slot_x >= count_x) begin
                    n_status = ST_UNKNOWN;
                    n_state  = S_RESP;
                end else begin
                    n_cur_slot = map_rdata;
                    n_state    = (r_func == FUNC_RAISE) ? S_UP_REQ : S_DN_REQ;
                end
            end

            // last entry moves to the root
            S_LAST_RD: begin
                n_cur_id   = rd_id;
                n_cur_key  = rd_key;
                n_cur_slot = '0;
                n_state    = S_DN_REQ;
            end

            S_UP_REQ: begin
                if (r_cur_slot == '0) begin
                    n_state = S_FIN;
                end else begin
                    heap_re = 1'b1;
                    n_state = S_UP_CMP;
                end
            end

            // parent moves down into the hole when strictly smaller
            S_UP_CMP: begin
                if (r_cur_key > rd_key) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    map_we     = 1'b1;
                    map_waddr  = rd_id;
                    n_cur_slot = parent_idx;
                    n_state    = S_UP_REQ;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_DN_REQ: begin
                if (left_idx >= count_x) begin
                    n_state = S_FIN;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = AW'(left_idx);
                    n_state    = S_DN_L;
                end
            end

            S_DN_L: begin
                n_left_id  = rd_id;
                n_left_key = rd_key;
                n_has_r    = right_idx < count_x;
                heap_re    = right_idx < count_x;
                heap_raddr = AW'(right_idx);
                n_state    = S_DN_R;
            end

            // larger child moves up into the hole when strictly greater than the moving entry
            S_DN_R: begin
                if (take_r) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    map_we     = 1'b1;
                    map_waddr  = rd_id;
                    n_cur_slot = AW'(right_idx);
                    n_state    = S_DN_REQ;
                end else if (take_l) begin
                    heap_we    = 1'b1;
                    heap_wdata = {r_left_id, r_left_key};
                    map_we     = 1'b1;
                    map_waddr  = r_left_id;
                    n_cur_slot = AW'(left_idx);
                    n_state    = S_DN_REQ;
                end else begin
                    n_state = S_FIN;
                end
            end

            // moving entry settles in its slot
            S_FIN: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_ov || i_out_ready) begin
                    n_ov          = 1'b1;
                    n_o_status    = r_status;
                    n_o_top_valid = r_count != '0;
                    n_o_top_id    = (r_count != '0) ? r_top_id : '0;
                    n_o_top_key   = (r_count != '0) ? IN_KEY_BITS'(r_top_key) : '0;
                    n_o_count     = COUNT_BITS'(r_count);
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // root copy follows every write to slot zero
        if (heap_we && heap_waddr == '0) begin
            n_top_id  = heap_wdata[EW-1 -: ID_BITS];
            n_top_key = heap_wdata[KEY_BITS-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_id_valid <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_id_valid <= n_id_valid;
            r_ov       <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_cur_id      <= n_cur_id;
        r_cur_key     <= n_cur_key;
        r_cur_slot    <= n_cur_slot;
        r_left_id     <= n_left_id;
        r_left_key    <= n_left_key;
        r_has_r       <= n_has_r;
        r_status      <= n_status;
        r_top_id      <= n_top_id;
        r_top_key     <= n_top_key;
        r_o_status    <= n_o_status;
        r_o_top_valid <= n_o_top_valid;
        r_o_top_id    <= n_o_top_id;
        r_o_top_key   <= n_o_top_key;
        r_o_count     <= n_o_count;
    end

    assign o_in_ready    = r_state == S_IDLE;
    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_top_valid   = r_o_top_valid;
    assign o_top_id      = r_o_top_id;
    assign o_top_key     = r_o_top_key;
    assign o_entry_count = r_o_count;

endmodule

>>> design/ihq_ram.sv
// ----------------------------------------------------------------------------
// ihq_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
